[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the peer directory block.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PDSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PDSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdsw_pkg.sv]
// Package for the peer directory block: opcodes, result kinds and the result beat.
// No dependencies; pdsw_if and the peer directory module use it.
package pdsw_pkg;

  localparam int OP_W      = 3;
  localparam int PADDR_W   = 3;
  localparam int RES_LIMIT = 8;

  localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE   = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd2;
  localparam logic [OP_W-1:0] OP_ACK      = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Register index of timeout_us, taken from paddr above the byte offset.
  localparam logic [0:0] REG_TIMEOUT = 1'b0;
  localparam logic [23:0] TIMEOUT_RESET = 24'd500000;

  // Bit 31 of a file map is file 0.
  localparam logic [4:0] FILE_MSB = 5'd31;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        seq;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic        last;
  } result_t;

endpackage

[hw/rtl/pdsw_if.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on pdsw_pkg for the opcode width.
interface pdsw_in_if;
  logic                      valid;
  logic                      ready;
  logic [pdsw_pkg::OP_W-1:0] op;
  logic [31:0]               client_ip;
  logic [15:0]               client_port;
  logic [31:0]               node_ip;
  logic [15:0]               node_port;
  logic [31:0]               file_bits;
  logic [6:0]                file_index;
  logic                      seq;
  logic [47:0]               time_us;

  modport source (output valid, op, client_ip, client_port, node_ip, node_port,
                  file_bits, file_index, seq, time_us, input ready);
  modport sink   (input valid, op, client_ip, client_port, node_ip, node_port,
                  file_bits, file_index, seq, time_us, output ready);
endinterface

interface pdsw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  logic        out_seq;
  logic [31:0] peer_ip;
  logic [15:0] peer_port;
  logic        last;

  modport source (output valid, kind, dest_ip, dest_port, out_seq, peer_ip, peer_port,
                  last, input ready);
  modport sink   (input valid, kind, dest_ip, dest_port, out_seq, peer_ip, peer_port,
                  last, output ready);
endinterface

[hw/rtl/peer_directory_stop_and_wait.sv]
// Peer directory with an alternating-bit responder per client.
// Channels: in_chan takes one request beat (register, update, query, ack, tick);
// out_chan gives the result beats of that request in order, last set on the final one.
// Configuration: APB-style write of timeout_us at byte address 0, pready always high.
// An item is taken only in the idle state, then walks the context table and the peer
// table, both in registered-read synchronous RAMs, with a read and a compare state per
// entry visited. A request from a known client walks the contexts up to its slot, then
// the peers; a tick reads each context and, for an overdue one, its peer before it
// resends. One item is in flight at a time; the next is taken once the last result of
// the current one sits in the output register.
// Reset clears the peer and client counts, the output and staging valid flags, and
// sets timeout_us to 500000. Table contents need no clearing: a new client slot is
// written in full when it is created.
// When the receiver stalls, results wait in a staging register and the output
// register; the walk holds until a slot frees, no result is dropped.
// Depends on pdsw_pkg, pdsw_if, pdsw_ram and assert_macros.svh.
`include "assert_macros.svh"

module peer_directory_stop_and_wait #(
  parameter int MAX_PEERS   = 16,
  parameter int MAX_CLIENTS = 8,
  parameter int FILE_COUNT  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pdsw_in_if.sink                      in_chan,
  pdsw_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdsw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pdsw_pkg::*;

  localparam int PW  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int PCW = $clog2(MAX_PEERS + 1);
  localparam int CW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CCW = $clog2(MAX_CLIENTS + 1);

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] files;
  } peer_word_t;

  typedef struct packed {
    logic [31:0]   addr;
    logic [15:0]   port;
    logic          waiting;
    logic          pseq;
    logic [PW-1:0] ppeer;
    logic [4:0]    file;
    logic [47:0]   sent;
  } ctx_word_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CRD   = 11'b00000000010,
    S_CCMP  = 11'b00000000100,
    S_DISP  = 11'b00000001000,
    S_PRD   = 11'b00000010000,
    S_PCMP  = 11'b00000100000,
    S_TRD   = 11'b00001000000,
    S_TCMP  = 11'b00010000000,
    S_TPRD  = 11'b00100000000,
    S_FLUSH = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  logic [OP_W-1:0] op_r, op_nxt;
  logic [31:0] cip_r, cip_nxt, nip_r, nip_nxt, fmap_r, fmap_nxt;
  logic [15:0] cport_r, cport_nxt, nport_r, nport_nxt;
  logic [6:0]  fidx_r, fidx_nxt;
  logic        sq_r, sq_nxt;
  logic [47:0] now_r, now_nxt;

  // Walk state.
  logic [PCW-1:0] pi_r, pi_nxt, peer_count_r, peer_count_nxt;
  logic [CCW-1:0] ci_r, ci_nxt, ctx_count_r, ctx_count_nxt;
  logic [3:0]     n_r, n_nxt;
  logic           c_ok_r, c_ok_nxt;
  logic [CW-1:0]  c_idx_r, c_idx_nxt;
  ctx_word_t      ce_r, ce_nxt;
  logic [4:0]     file_r, file_nxt;
  logic [23:0]    timeout_r;

  // Staging and output registers.
  logic    stg_v_r, stg_v_nxt, out_v_r, out_v_nxt;
  result_t stg_r, stg_nxt, out_r, out_nxt;

  // Memory ports.
  logic p_we, p_re, c_we, c_re;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [CW-1:0] c_waddr, c_raddr;
  peer_word_t p_wdata, p_rd;
  ctx_word_t  c_wdata, c_rd, cw;

  logic    slot_free, blocked, emit, overdue;
  result_t emit_val;

  pdsw_ram #(.DEPTH(MAX_PEERS), .WIDTH($bits(peer_word_t)), .AW(PW)) u_peer_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rd)
  );

  pdsw_ram #(.DEPTH(MAX_CLIENTS), .WIDTH($bits(ctx_word_t)), .AW(CW)) u_ctx_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rd)
  );

  assign slot_free = !out_v_r || out_chan.ready;
  assign blocked   = stg_v_r && !slot_free;
  assign overdue   = c_rd.waiting && (now_r >= c_rd.sent) &&
                     ((now_r - c_rd.sent) >= 48'(timeout_r));

  assign in_chan.ready = (state_r == S_IDLE);

  // Sequencer: context lookup, peer walk, tick walk and result staging.
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; cip_nxt = cip_r; cport_nxt = cport_r; nip_nxt = nip_r;
    nport_nxt = nport_r; fmap_nxt = fmap_r; fidx_nxt = fidx_r; sq_nxt = sq_r;
    now_nxt = now_r;
    pi_nxt = pi_r; ci_nxt = ci_r; n_nxt = n_r;
    peer_count_nxt = peer_count_r; ctx_count_nxt = ctx_count_r;
    c_ok_nxt = c_ok_r; c_idx_nxt = c_idx_r; ce_nxt = ce_r; file_nxt = file_r;
    stg_v_nxt = stg_v_r; stg_nxt = stg_r;
    out_v_nxt = out_v_r && !out_chan.ready; out_nxt = out_r;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
    cw = ce_r;
    emit = 1'b0;
    emit_val = '0;
    emit_val.dest_ip = cip_r;
    emit_val.dest_port = cport_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt = in_chan.op; cip_nxt = in_chan.client_ip;
          cport_nxt = in_chan.client_port; nip_nxt = in_chan.node_ip;
          nport_nxt = in_chan.node_port; fmap_nxt = in_chan.file_bits;
          fidx_nxt = in_chan.file_index; sq_nxt = in_chan.seq;
          now_nxt = in_chan.time_us;
          ci_nxt = '0;
          n_nxt = '0;
          if (in_chan.op == OP_TICK) begin
            state_nxt = S_TRD;
          end else if (in_chan.op == OP_REGISTER || in_chan.op == OP_UPDATE ||
                       in_chan.op == OP_QUERY || in_chan.op == OP_ACK) begin
            state_nxt = S_CRD;
          end
        end
      end

      // Look for the client's context; create one if absent and there is room.
      S_CRD: begin
        if (ci_r < ctx_count_r) begin
          c_re = 1'b1;
          c_raddr = ci_r[CW-1:0];
          state_nxt = S_CCMP;
        end else begin
          if (ctx_count_r < CCW'(MAX_CLIENTS)) begin
            cw = '0;
            cw.addr = cip_r;
            cw.port = cport_r;
            ce_nxt = cw;
            c_we = 1'b1;
            c_waddr = ctx_count_r[CW-1:0];
            c_wdata = cw;
            c_ok_nxt = 1'b1;
            c_idx_nxt = ctx_count_r[CW-1:0];
            ctx_count_nxt = ctx_count_r + CCW'(1);
          end else begin
            c_ok_nxt = 1'b0;
          end
          state_nxt = S_DISP;
        end
      end

      S_CCMP: begin
        if (c_rd.addr == cip_r && c_rd.port == cport_r) begin
          c_ok_nxt = 1'b1;
          c_idx_nxt = ci_r[CW-1:0];
          ce_nxt = c_rd;
          state_nxt = S_DISP;
        end else begin
          ci_nxt = ci_r + CCW'(1);
          state_nxt = S_CRD;
        end
      end

      // Decide what the request does and where the peer walk starts.
      S_DISP: begin
        pi_nxt = '0;
        case (op_r)
          OP_REGISTER, OP_UPDATE: begin
            state_nxt = S_PRD;
          end
          OP_QUERY: begin
            if (32'(fidx_r) >= FILE_COUNT) begin
              state_nxt = S_IDLE;
            end else begin
              emit = 1'b1;
              emit_val.kind = KIND_ACK;
              emit_val.seq = sq_r;
              file_nxt = fidx_r[4:0];
              state_nxt = S_PRD;
            end
          end
          OP_ACK: begin
            if (c_ok_r && ce_r.waiting && ce_r.pseq == sq_r) begin
              file_nxt = ce_r.file;
              pi_nxt = PCW'(ce_r.ppeer) + PCW'(1);
              state_nxt = S_PRD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Peer walk: read the next peer, or act on reaching the end of the table.
      S_PRD: begin
        if (pi_r < peer_count_r) begin
          p_re = 1'b1;
          p_raddr = pi_r[PW-1:0];
          state_nxt = S_PCMP;
        end else begin
          case (op_r)
            OP_REGISTER: begin
              if (peer_count_r < PCW'(MAX_PEERS)) begin
                p_we = 1'b1;
                p_waddr = peer_count_r[PW-1:0];
                p_wdata = '{addr: nip_r, port: nport_r, files: 32'd0};
                peer_count_nxt = peer_count_r + PCW'(1);
              end
              emit = 1'b1;
              emit_val.kind = KIND_ACK;
              emit_val.seq = sq_r;
              state_nxt = S_FLUSH;
            end
            OP_UPDATE: begin
              state_nxt = S_IDLE;
            end
            default: begin
              if (!blocked) begin
                emit = 1'b1;
                emit_val.kind = KIND_FINISH;
                emit_val.seq = ~sq_r;
                cw.waiting = 1'b0;
                if (op_r == OP_ACK) begin
                  cw.pseq = ~sq_r;
                  cw.sent = now_r;
                end
                c_we = c_ok_r;
                c_waddr = c_idx_r;
                c_wdata = cw;
                state_nxt = S_FLUSH;
              end
            end
          endcase
        end
      end

      S_PCMP: begin
        if (op_r == OP_REGISTER || op_r == OP_UPDATE) begin
          if (p_rd.addr == nip_r && p_rd.port == nport_r) begin
            if (op_r == OP_UPDATE) begin
              p_we = 1'b1;
              p_waddr = pi_r[PW-1:0];
              p_wdata = '{addr: nip_r, port: nport_r, files: fmap_r};
            end
            emit = 1'b1;
            emit_val.kind = KIND_ACK;
            emit_val.seq = sq_r;
            state_nxt = S_FLUSH;
          end else begin
            pi_nxt = pi_r + PCW'(1);
            state_nxt = S_PRD;
          end
        end else if (p_rd.files[FILE_MSB - file_r]) begin
          if (!blocked) begin
            emit = 1'b1;
            emit_val.kind = KIND_RESP;
            emit_val.seq = (op_r == OP_QUERY) ? 1'b0 : ~sq_r;
            emit_val.peer_ip = p_rd.addr;
            emit_val.peer_port = p_rd.port;
            cw.ppeer = pi_r[PW-1:0];
            cw.sent = now_r;
            if (op_r == OP_QUERY) begin
              cw.waiting = 1'b1;
              cw.pseq = 1'b0;
              cw.file = fidx_r[4:0];
            end else begin
              cw.pseq = ~sq_r;
            end
            c_we = c_ok_r;
            c_waddr = c_idx_r;
            c_wdata = cw;
            state_nxt = S_FLUSH;
          end
        end else begin
          pi_nxt = pi_r + PCW'(1);
          state_nxt = S_PRD;
        end
      end

      // Tick walk over the contexts, at most RES_LIMIT resends.
      S_TRD: begin
        if (ci_r < ctx_count_r && n_r < 4'(RES_LIMIT)) begin
          c_re = 1'b1;
          c_raddr = ci_r[CW-1:0];
          state_nxt = S_TCMP;
        end else begin
          state_nxt = S_FLUSH;
        end
      end

      S_TCMP: begin
        if (overdue) begin
          ce_nxt = c_rd;
          p_re = 1'b1;
          p_raddr = c_rd.ppeer;
          state_nxt = S_TPRD;
        end else begin
          ci_nxt = ci_r + CCW'(1);
          state_nxt = S_TRD;
        end
      end

      S_TPRD: begin
        if (!blocked) begin
          emit = 1'b1;
          emit_val.kind = KIND_RESP;
          emit_val.dest_ip = ce_r.addr;
          emit_val.dest_port = ce_r.port;
          emit_val.seq = ce_r.pseq;
          emit_val.peer_ip = p_rd.addr;
          emit_val.peer_port = p_rd.port;
          cw.sent = now_r;
          c_we = 1'b1;
          c_waddr = ci_r[CW-1:0];
          c_wdata = cw;
          n_nxt = n_r + 4'd1;
          ci_nxt = ci_r + CCW'(1);
          state_nxt = S_TRD;
        end
      end

      // Hand the staged beat over as the final one.
      S_FLUSH: begin
        if (!stg_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_v_nxt = 1'b1;
          out_nxt = stg_r;
          out_nxt.last = 1'b1;
          stg_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new result pushes the staged one to the output register.
    if (emit) begin
      if (stg_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt = stg_r;
        out_nxt.last = 1'b0;
      end
      stg_v_nxt = 1'b1;
      stg_nxt = emit_val;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      peer_count_r <= '0;
      ctx_count_r <= '0;
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
      n_r <= '0;
      c_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      peer_count_r <= peer_count_nxt;
      ctx_count_r <= ctx_count_nxt;
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
      n_r <= n_nxt;
      c_ok_r <= c_ok_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt; cip_r <= cip_nxt; cport_r <= cport_nxt; nip_r <= nip_nxt;
    nport_r <= nport_nxt; fmap_r <= fmap_nxt; fidx_r <= fidx_nxt; sq_r <= sq_nxt;
    now_r <= now_nxt;
    pi_r <= pi_nxt; ci_r <= ci_nxt; c_idx_r <= c_idx_nxt; ce_r <= ce_nxt;
    file_r <= file_nxt; stg_r <= stg_nxt; out_r <= out_nxt;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_TIMEOUT) begin
      timeout_r <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT) ? {8'd0, timeout_r} : 32'd0;

  // Result channel.
  assign out_chan.valid     = out_v_r;
  assign out_chan.kind      = out_r.kind;
  assign out_chan.dest_ip   = out_r.dest_ip;
  assign out_chan.dest_port = out_r.dest_port;
  assign out_chan.out_seq   = out_r.seq;
  assign out_chan.peer_ip   = out_r.peer_ip;
  assign out_chan.peer_port = out_r.peer_port;
  assign out_chan.last      = out_r.last;

  // Checks on the table counts, the tick limit, the staging register and query routing.
  `PDSW_ASSERT_IMPL(a_peer_count, 1'b1, peer_count_r <= PCW'(MAX_PEERS), "peer count overflow")
  `PDSW_ASSERT_IMPL(a_ctx_count, 1'b1, ctx_count_r <= CCW'(MAX_CLIENTS), "ctx count overflow")
  `PDSW_ASSERT_IMPL(a_tick_limit, 1'b1, n_r <= 4'(RES_LIMIT), "too many resends in one tick")
  `PDSW_ASSERT_IMPL(a_idle_empty, state_r == S_IDLE, !stg_v_r, "result left staged while idle")
  `PDSW_ASSERT_NEXT(a_take_busy, in_chan.valid && in_chan.ready && in_chan.op == OP_QUERY,
                    state_r == S_CRD, "query not routed to context lookup")

endmodule

[hw/rtl/pdsw_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module pdsw_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
